// File: src/lzhc_pkg.sv
// Shared types and operation codes for the LZ77 hash chain table.
`timescale 1ns / 1ps

package lzhc_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_NEXT   = 2'd1;
    localparam logic [1:0] FUNC_SLIDE  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  new_byte;
        logic [15:0] position;
        logic [14:0] hash_in;
        logic [15:0] chain_position;
    } req_t;

    typedef struct packed {
        logic [15:0] match_head;
        logic [14:0] hash_out;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic sweep;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic clear_end;
        logic sweep_end;
    } status_t;

endpackage

// File: src/lzhc_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module lzhc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/lzhc_ctrl.sv
// Controller state machine for the LZ77 hash chain table.
`timescale 1ns / 1ps

module lzhc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       func,
    input  lzhc_pkg::status_t status,
    output lzhc_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             done
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_SLIDE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        done        = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (func == lzhc_pkg::FUNC_SLIDE) ? ST_SLIDE : ST_EXEC;
                end
            end
            ST_SLIDE:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_end)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// File: src/lzhc_dp.sv
// Datapath for the LZ77 hash chain table: head and prev memories, sweep counter.
`timescale 1ns / 1ps

module lzhc_dp #(
    parameter int HASH_WIDTH    = 15,
    parameter int WINDOW_SIZE   = 32768,
    parameter int MIN_MATCH_LEN = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lzhc_pkg::req_t    req,
    input  lzhc_pkg::cmd_t    cmd,
    output lzhc_pkg::status_t status,
    output lzhc_pkg::rsp_t    rsp
);

    localparam int HEAD_DEPTH = 1 << HASH_WIDTH;
    localparam int PW         = $clog2(WINDOW_SIZE);
    localparam int MAXD       = (HEAD_DEPTH > WINDOW_SIZE) ? HEAD_DEPTH : WINDOW_SIZE;
    localparam int CW         = $clog2(MAXD + 1);
    localparam int SHIFT_AMT  = (HASH_WIDTH + MIN_MATCH_LEN - 1) / MIN_MATCH_LEN;

    // position modulo window: conditional subtract of window << k, k = 7..0
    function automatic logic [PW-1:0] win_idx(input logic [15:0] p);
        logic [24:0] x;
        logic [24:0] step;
        x = {9'd0, p};
        for (int k = 7; k >= 0; k--)
        begin
            step = 25'(WINDOW_SIZE) << k;
            if (x >= step)
            begin
                x = x - step;
            end
        end
        return PW'(x);
    endfunction

    function automatic logic [15:0] rebase(input logic [15:0] v);
        logic [16:0] x;
        x = {1'b0, v};
        if (x >= 17'(WINDOW_SIZE))
        begin
            return 16'(x - 17'(WINDOW_SIZE));
        end
        return 16'd0;
    endfunction

    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [CW-1:0]         cnt_m1;
    logic [1:0]            func_reg;
    logic [15:0]           pos_reg;
    logic [14:0]           hin_reg;
    logic [HASH_WIDTH-1:0] h_reg;
    logic [PW-1:0]         pidx_reg;
    logic [HASH_WIDTH-1:0] h_comb;

    logic                  head_we;
    logic [HASH_WIDTH-1:0] head_waddr;
    logic [15:0]           head_wdata;
    logic [HASH_WIDTH-1:0] head_raddr;
    logic [15:0]           head_rdata;
    logic                  prev_we;
    logic [PW-1:0]         prev_waddr;
    logic [15:0]           prev_wdata;
    logic [PW-1:0]         prev_raddr;
    logic [15:0]           prev_rdata;

    assign h_comb   = HASH_WIDTH'((32'(req.hash_in) << SHIFT_AMT) ^ 32'(req.new_byte));
    assign cnt_m1   = cnt_reg - CW'(1);
    assign cnt_next = (cmd.clear || cmd.sweep) ? cnt_reg + CW'(1) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= req.func;
            pos_reg  <= req.position;
            hin_reg  <= req.hash_in;
            h_reg    <= h_comb;
            pidx_reg <= win_idx(req.position);
        end
    end

    assign status.clear_end = (cnt_reg == CW'(MAXD - 1));
    assign status.sweep_end = (cnt_reg == CW'(MAXD));

    assign head_raddr = cmd.sweep ? HASH_WIDTH'(cnt_reg) : h_comb;
    assign prev_raddr = cmd.sweep ? PW'(cnt_reg) : win_idx(req.chain_position);

    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = h_reg;
        head_wdata = pos_reg;
        prev_we    = 1'b0;
        prev_waddr = pidx_reg;
        prev_wdata = head_rdata;
        priority if (cmd.clear)
        begin
            head_we    = (cnt_reg < CW'(HEAD_DEPTH));
            head_waddr = HASH_WIDTH'(cnt_reg);
            head_wdata = 16'd0;
            prev_we    = (cnt_reg < CW'(WINDOW_SIZE));
            prev_waddr = PW'(cnt_reg);
            prev_wdata = 16'd0;
        end
        else if (cmd.sweep)
        begin
            // write back entry cnt-1, which was read in the previous cycle
            head_we    = (cnt_reg != '0) && (cnt_reg <= CW'(HEAD_DEPTH));
            head_waddr = HASH_WIDTH'(cnt_m1);
            head_wdata = rebase(head_rdata);
            prev_we    = (cnt_reg != '0) && (cnt_reg <= CW'(WINDOW_SIZE));
            prev_waddr = PW'(cnt_m1);
            prev_wdata = rebase(prev_rdata);
        end
        else if (cmd.exec && (func_reg == lzhc_pkg::FUNC_INSERT))
        begin
            head_we = 1'b1;
            prev_we = 1'b1;
        end
    end

    always_comb
    begin
        rsp.match_head = 16'd0;
        rsp.hash_out   = hin_reg;
        if (func_reg == lzhc_pkg::FUNC_INSERT)
        begin
            rsp.match_head = head_rdata;
            rsp.hash_out   = 15'(h_reg);
        end
        else if (func_reg == lzhc_pkg::FUNC_NEXT)
        begin
            rsp.match_head = prev_rdata;
        end
    end

    lzhc_ram #(
        .WIDTH (16),
        .DEPTH (HEAD_DEPTH)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    lzhc_ram #(
        .WIDTH (16),
        .DEPTH (WINDOW_SIZE)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

endmodule

// File: src/lz77_hash_chain_table_top.sv
// Top level of the LZ77 hash chain table: controller plus datapath.
//
//  channel   ports            handshake
//  request   req (req_t)      accepted at clk edge with start high and busy low
//  result    rsp (rsp_t)      valid for one cycle while done is high, no backpressure
//
// Insert, next and unused codes pass through accept (memory read issued) and execute
// (head/prev written on insert only, result strobed); slide adds a sweep between them.
// MAXD is the larger of the head and prev depths: both memories are swept one entry per
// cycle in parallel over MAXD entries. After reset a clear zeroes both, busy held high.
// Results are never stalled; the next request is taken the cycle after done.
`timescale 1ns / 1ps

module lz77_hash_chain_table_top #(
    parameter int HASH_WIDTH    = 15,
    parameter int WINDOW_SIZE   = 32768,
    parameter int MIN_MATCH_LEN = 3
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lzhc_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output lzhc_pkg::rsp_t rsp
);

    lzhc_pkg::cmd_t    cmd;
    lzhc_pkg::status_t status;

    lzhc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (req.func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    lzhc_dp #(
        .HASH_WIDTH    (HASH_WIDTH),
        .WINDOW_SIZE   (WINDOW_SIZE),
        .MIN_MATCH_LEN (MIN_MATCH_LEN)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule
